### hdl/bsh_pkg.sv
package bsh_pkg;

  // hash constants
  localparam logic [31:0] GOLDEN_WORD = 32'h9E3779B9;
  localparam logic [31:0] SEED_RESET  = 32'hABCDEF00;
  localparam int unsigned BLOCK_BYTES = 12;
  localparam int unsigned TAIL_BYTES  = BLOCK_BYTES - 1;
  localparam int unsigned MIX_STEPS   = 9;

  // three hash words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // leftover bytes, byte 0 in the low lane
  typedef logic [TAIL_BYTES-1:0][7:0] tail_t;

  // one step of the mix, selected by its position
  function automatic words_t mix_step(input int unsigned step, input words_t w);
    words_t r;
    r = w;
    case (step)
      0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

  // add the length and the leftover bytes; low byte of c is kept for the length
  function automatic words_t tail_add(input words_t w, input tail_t tb,
                                      input logic [31:0] len);
    words_t r;
    r.a = w.a + tb[3:0];
    r.b = w.b + tb[7:4];
    r.c = w.c + len + {tb[10:8], 8'h00};
    return r;
  endfunction

endpackage

### hdl/bsh_ifs.sv
// message byte channel
interface bsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

// hash result channel
interface bsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

// seed register write channel
interface bsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/byte_string_hash32.sv
// 32-bit lookup2 hash of a byte message, one byte per input word.
// msg carries data_byte, has_byte and last; a word with has_byte low and
// last high closes a message without adding a byte (empty message allowed).
// hash returns one hash_value per message, after the word marked last.
// cfg writes the seed; it takes effect at once if no byte of the current
// message has arrived, otherwise from the next message. cfg is always ready.
// Throughput: one input word per cycle while msg.ready is high. The block
// mix runs in a 9-stage pipeline, one mix step per stage, shared by block
// and final mixes. When a message ends on a full block or while its last
// block is still mixing, the block is sent through the pipeline again for
// the final mix; msg.ready is low in the cycle in which it re-enters, and
// a word marked last waits until that re-entry so hashes leave in message
// order. hash.valid is set from the output register once the final mix
// leaves the last pipeline stage, behind the block mix when chained.
// Reset (rst, synchronous) empties the pipeline and output register and
// sets the seed to 0xABCDEF00. If hash is stalled with a result waiting,
// input words keep flowing until the next result reaches the pipeline end;
// the pipeline then holds and msg.ready is low.
module byte_string_hash32 (
  input logic      clk,
  input logic      rst,
  bsh_in_if.sink   msg,
  bsh_out_if.source hash,
  bsh_cfg_if.sink  cfg
);

  localparam int unsigned STAGES = bsh_pkg::MIX_STEPS;

  // message state
  logic [31:0]         seed;
  bsh_pkg::words_t     acc;
  bsh_pkg::tail_t      pend;
  logic [3:0]          fill;
  logic [31:0]         byte_count;
  logic                busy;
  logic                chain_pending;
  bsh_pkg::tail_t      chain_tail;
  logic [31:0]         chain_len;

  // mix pipeline
  logic [STAGES-1:0]   p_valid;
  logic [STAGES-1:0]   p_final;
  bsh_pkg::words_t     p_words [STAGES];

  // output register
  logic                out_valid;
  logic [31:0]         out_hash;

  // combinational
  bsh_pkg::words_t     exit_w;
  logic                exit_block;
  logic                exit_result;
  logic                advance;
  logic                reenter;
  logic                writeback;
  logic                take_item;
  logic                take_byte;
  logic                end_msg;
  logic                blk_done;
  logic                busy_eff;
  logic                direct_final;
  logic                chain_start;
  bsh_pkg::words_t     eff;
  bsh_pkg::words_t     blk_w;
  bsh_pkg::words_t     entry_w;
  logic                entry_valid;
  logic                entry_final;
  logic [31:0]         count_next;
  logic [3:0]          fill_next;
  bsh_pkg::tail_t      tail_masked;

  // pipeline exit and stall
  assign exit_w      = p_words[STAGES-1];
  assign exit_block  = p_valid[STAGES-1] && !p_final[STAGES-1];
  assign exit_result = p_valid[STAGES-1] && p_final[STAGES-1];
  assign advance     = !(exit_result && out_valid && !hash.ready);
  assign reenter     = exit_block && chain_pending;
  assign writeback   = exit_block && !chain_pending;

  // handshakes, a closing word waits behind a chained final mix
  assign msg.ready       = advance && !reenter && !(chain_pending && msg.last);
  assign cfg.ready       = 1'b1;
  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;

  assign take_item = msg.valid && msg.ready;
  assign take_byte = take_item && msg.has_byte;
  assign end_msg   = take_item && msg.last;
  assign blk_done  = take_byte && (fill == 4'(bsh_pkg::TAIL_BYTES));

  // words of the current message, bypassing a block mix that ends now
  assign eff      = writeback ? exit_w : acc;
  assign busy_eff = busy && !writeback;

  assign count_next = byte_count + 32'(take_byte);

  always_comb begin
    if (blk_done) begin
      fill_next = '0;
    end else if (take_byte) begin
      fill_next = fill + 4'd1;
    end else begin
      fill_next = fill;
    end
  end

  // leftover bytes including the incoming one, unused lanes zeroed
  always_comb begin
    for (int i = 0; i < bsh_pkg::TAIL_BYTES; i++) begin
      if (4'(i) >= fill_next) begin
        tail_masked[i] = 8'h00;
      end else if (take_byte && !blk_done && (fill == 4'(i))) begin
        tail_masked[i] = msg.data_byte;
      end else begin
        tail_masked[i] = pend[i];
      end
    end
  end

  // full block added into the words
  assign blk_w.a = eff.a + pend[3:0];
  assign blk_w.b = eff.b + pend[7:4];
  assign blk_w.c = eff.c + {msg.data_byte, pend[10:8]};

  assign direct_final = end_msg && !blk_done && !busy_eff;
  assign chain_start  = end_msg && (blk_done || busy_eff);

  // pipeline entry select
  always_comb begin
    entry_valid = 1'b0;
    entry_final = 1'b0;
    entry_w     = eff;
    if (reenter) begin
      entry_valid = 1'b1;
      entry_final = 1'b1;
      entry_w     = bsh_pkg::tail_add(exit_w, chain_tail, chain_len);
    end else if (blk_done) begin
      entry_valid = 1'b1;
      entry_w     = blk_w;
    end else if (direct_final) begin
      entry_valid = 1'b1;
      entry_final = 1'b1;
      entry_w     = bsh_pkg::tail_add(eff, tail_masked, count_next);
    end
  end

  // message state and seed
  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= bsh_pkg::SEED_RESET;
      acc.a         <= bsh_pkg::GOLDEN_WORD;
      acc.b         <= bsh_pkg::GOLDEN_WORD;
      acc.c         <= bsh_pkg::SEED_RESET;
      fill          <= '0;
      byte_count    <= '0;
      busy          <= 1'b0;
      chain_pending <= 1'b0;
    end else begin
      if (cfg.valid) begin
        seed <= cfg.data;
        if ((byte_count == '0) && !end_msg && !writeback) begin
          acc.c <= cfg.data;
        end
      end
      if (end_msg) begin
        acc.a      <= bsh_pkg::GOLDEN_WORD;
        acc.b      <= bsh_pkg::GOLDEN_WORD;
        acc.c      <= cfg.valid ? cfg.data : seed;
        fill       <= '0;
        byte_count <= '0;
        busy       <= 1'b0;
      end else begin
        if (writeback) begin
          acc  <= exit_w;
          busy <= 1'b0;
        end
        if (take_byte) begin
          byte_count <= count_next;
          fill       <= fill_next;
          if (blk_done) begin
            busy <= 1'b1;
          end
        end
      end
      if (chain_start) begin
        chain_pending <= 1'b1;
      end else if (reenter && advance) begin
        chain_pending <= 1'b0;
      end
    end
  end

  // pending bytes and chained tail
  always_ff @(posedge clk) begin
    if (take_byte && !blk_done) begin
      pend[fill] <= msg.data_byte;
    end
    if (chain_start) begin
      chain_tail <= tail_masked;
      chain_len  <= count_next;
    end
  end

  // mix pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= '0;
      p_final <= '0;
    end else if (advance) begin
      p_valid <= {p_valid[STAGES-2:0], entry_valid};
      p_final <= {p_final[STAGES-2:0], entry_final};
    end
  end

  // mix pipeline data, one step per stage
  always_ff @(posedge clk) begin
    if (advance) begin
      p_words[0] <= bsh_pkg::mix_step(0, entry_w);
      for (int s = 1; s < STAGES; s++) begin
        p_words[s] <= bsh_pkg::mix_step(s, p_words[s-1]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && exit_result) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && exit_result) begin
      out_hash <= exit_w.c;
    end
  end

  // a chained final mix needs its block still in the pipeline
  a_chain_has_block: assert property (@(posedge clk) disable iff (rst)
    chain_pending |-> (|(p_valid & ~p_final)))
    else $error("chained final without block job in flight");

  // a busy message has its block mix in the pipeline
  a_busy_has_block: assert property (@(posedge clk) disable iff (rst)
    busy |-> (|(p_valid & ~p_final)))
    else $error("busy without block job in flight");

  // block mixes never overlap
  a_one_block: assert property (@(posedge clk) disable iff (rst)
    $countones(p_valid & ~p_final) <= 1)
    else $error("more than one block job in flight");

  // fill count stays within the leftover buffer
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 4'(bsh_pkg::TAIL_BYTES))
    else $error("fill count out of range");

  // a stall freezes the pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(p_valid) && $stable(p_final))
    else $error("pipeline moved during stall");

endmodule
